### rtl/core/bsrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrm_pkg
// Shared types and constants for the backing store range map unit.
// ----------------------------------------------------------------------------
package bsrm_pkg;

  localparam int unsigned STORE_COUNT   = 16;
  localparam int unsigned PROCESS_COUNT = 32;

  localparam int unsigned STORE_W  = 4;   // store_number field
  localparam int unsigned PID_W    = 5;   // process_id field
  localparam int unsigned VADDR_W  = 32;
  localparam int unsigned PAGE_W   = 20;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned OFS_W    = 7;
  localparam int unsigned ADDR_W   = STORE_W + PID_W;
  localparam int unsigned MEM_DEPTH = STORE_COUNT * PROCESS_COUNT;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned MAX_MAP_PAGES = 128;

  localparam int unsigned IN_DATA_W  = 72;  // 69 payload bits, byte padded
  localparam int unsigned OUT_DATA_W = 16;  // 12 payload bits, byte padded

  typedef enum logic [1:0] {
    OP_GET_FREE = 2'd0,
    OP_FREE     = 2'd1,
    OP_MAP      = 2'd2,
    OP_LOOKUP   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  // update of the per-store flop table
  typedef struct packed {
    logic               free_en;
    logic               map_en;
    logic [STORE_W-1:0] store;
    logic [PID_W-1:0]   pid;
    logic [CNT_W-1:0]   pages;
  } store_cmd_t;

  typedef struct packed {
    logic [OFS_W-1:0]   page_offset;
    logic [STORE_W-1:0] found_store;
    logic               ok;
  } result_t;

endpackage

### rtl/core/bsrm_base_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrm_base_mem
// Base page memory, one entry per store and process, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module bsrm_base_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bsrm_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [bsrm_pkg::PAGE_W-1:0]   wdata_i,
  input  logic [bsrm_pkg::ADDR_W-1:0]   raddr_i,
  output logic [bsrm_pkg::PAGE_W-1:0]   rdata_o
);

  logic [bsrm_pkg::PAGE_W-1:0] mem_q [bsrm_pkg::MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/bsrm_store_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrm_store_regs
// Per-store mapped flags, page counts and process valid bits, plus the
// lowest-unmapped-store search.
// ----------------------------------------------------------------------------
module bsrm_store_regs (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  bsrm_pkg::store_cmd_t                                    cmd_i,
  output logic [bsrm_pkg::STORE_COUNT-1:0][bsrm_pkg::CNT_W-1:0]   pages_o,
  output logic [bsrm_pkg::STORE_COUNT-1:0][bsrm_pkg::PROCESS_COUNT-1:0] valid_o,
  output logic                                                    free_found_o,
  output logic [bsrm_pkg::STORE_W-1:0]                            free_idx_o
);

  logic [bsrm_pkg::STORE_COUNT-1:0]                              mapped_q;
  logic [bsrm_pkg::STORE_COUNT-1:0][bsrm_pkg::CNT_W-1:0]         pages_q;
  logic [bsrm_pkg::STORE_COUNT-1:0][bsrm_pkg::PROCESS_COUNT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q <= '0;
      pages_q  <= '0;
      valid_q  <= '0;
    end else if (cmd_i.free_en) begin
      mapped_q[cmd_i.store] <= 1'b0;
      pages_q[cmd_i.store]  <= '0;
      valid_q[cmd_i.store]  <= '0;
    end else if (cmd_i.map_en) begin
      mapped_q[cmd_i.store]           <= 1'b1;
      pages_q[cmd_i.store]            <= cmd_i.pages;
      valid_q[cmd_i.store][cmd_i.pid] <= 1'b1;
    end
  end

  // lowest unmapped store; walk from the top so the lowest index wins
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = bsrm_pkg::STORE_COUNT - 1; i >= 0; i--) begin
      if (!mapped_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = bsrm_pkg::STORE_W'(i);
      end
    end
  end

  assign pages_o = pages_q;
  assign valid_o = valid_q;

endmodule

### rtl/core/backing_store_range_map_unit.sv
`timescale 1ns / 1ps
// Get-free, free and map answer on the cycle after accept; a lookup steps
//   through the scan and response states (one store compared per cycle).
// Get-free, free and map may follow each other while output is free; lookup
//   holds the input until done, one base page memory read per store scanned.
// Reset clears mapped flags, page counts and valid bits at once; the base
//   page memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// backing_store_range_map_unit
// Backing store table: get-free, free, map and address lookup over a stream.
// ----------------------------------------------------------------------------
module backing_store_range_map_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, low bit up: process_id[4:0], virtual_address[36:5],
  // base_page[56:37], store_number[60:57], page_count[68:61], zero pad
  input  logic [bsrm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, low bit up: ok[0], found_store[4:1], page_offset[11:5], zero pad
  output logic [bsrm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned StoreW = bsrm_pkg::STORE_W;
  localparam int unsigned PidW   = bsrm_pkg::PID_W;
  localparam int unsigned PageW  = bsrm_pkg::PAGE_W;
  localparam int unsigned CntW   = bsrm_pkg::CNT_W;

  // input unpack
  bsrm_pkg::opcode_e  in_op;
  logic [PidW-1:0]    in_pid;
  logic [31:0]        in_vaddr;
  logic [PageW-1:0]   in_base;
  logic [StoreW-1:0]  in_store;
  logic [CntW-1:0]    in_cnt;

  assign in_op    = bsrm_pkg::opcode_e'(s_axis_tuser);
  assign in_pid   = s_axis_tdata[4:0];
  assign in_vaddr = s_axis_tdata[36:5];
  assign in_base  = s_axis_tdata[56:37];
  assign in_store = s_axis_tdata[60:57];
  assign in_cnt   = s_axis_tdata[68:61];

  bsrm_pkg::state_e   state_q, state_d;
  logic [StoreW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [PidW-1:0]    pid_q;
  logic               pid_ok_q;
  logic [PageW-1:0]   page_q;
  bsrm_pkg::result_t  res_q, res_d;
  logic               out_valid_q, out_valid_d;
  bsrm_pkg::result_t  out_q, out_d;

  logic               accept;
  logic               out_free;
  logic               store_ok;
  logic               cnt_ok;
  logic               pid_ok;
  bsrm_pkg::store_cmd_t cmd;

  logic [bsrm_pkg::STORE_COUNT-1:0][CntW-1:0]                   pages;
  logic [bsrm_pkg::STORE_COUNT-1:0][bsrm_pkg::PROCESS_COUNT-1:0] valid;
  logic               free_found;
  logic [StoreW-1:0]  free_idx;

  logic               mem_we;
  logic [bsrm_pkg::ADDR_W-1:0] mem_raddr;
  logic [PageW-1:0]   mem_rdata;

  logic [PageW:0]     range_hi;
  logic               hit;
  logic               last;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == bsrm_pkg::ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign store_ok = {1'b0, in_store} < (StoreW + 1)'(bsrm_pkg::STORE_COUNT);
  assign pid_ok   = {1'b0, in_pid} < (PidW + 1)'(bsrm_pkg::PROCESS_COUNT);
  assign cnt_ok   = (in_cnt != '0) && ({1'b0, in_cnt} <= (CntW + 1)'(bsrm_pkg::MAX_MAP_PAGES));

  always_comb begin
    cmd         = '0;
    cmd.store   = in_store;
    cmd.pid     = in_pid;
    cmd.pages   = in_cnt;
    cmd.free_en = accept && (in_op == bsrm_pkg::OP_FREE) && store_ok;
    cmd.map_en  = accept && (in_op == bsrm_pkg::OP_MAP) && store_ok && cnt_ok && pid_ok;
  end

  bsrm_store_regs u_store_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .pages_o      (pages),
    .valid_o      (valid),
    .free_found_o (free_found),
    .free_idx_o   (free_idx)
  );

  // map writes on its accept edge; a later lookup reads after that edge,
  // so read and write to the same entry never overlap
  assign mem_we = cmd.map_en;

  // first store is read on the accept edge, then one store ahead of compare
  assign mem_raddr = (state_q == bsrm_pkg::ST_IDLE) ? {StoreW'(0), in_pid}
                                                   : {cmp_idx_q + StoreW'(1), pid_q};

  bsrm_base_mem u_base_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({in_store, in_pid}),
    .wdata_i (in_base),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // range end without wrap
  assign range_hi = {1'b0, mem_rdata} + (PageW + 1)'(pages[cmp_idx_q]);
  assign hit  = pid_ok_q && valid[cmp_idx_q][pid_q]
             && (page_q >= mem_rdata) && ({1'b0, page_q} < range_hi);
  assign last = (cmp_idx_q == StoreW'(bsrm_pkg::STORE_COUNT - 1));

  always_comb begin
    state_d     = state_q;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bsrm_pkg::ST_IDLE: begin
        if (accept) begin
          out_d = '0;
          unique case (in_op)
            bsrm_pkg::OP_GET_FREE: begin
              out_d.ok          = free_found;
              out_d.found_store = free_found ? free_idx : '0;
              out_valid_d       = 1'b1;
            end
            bsrm_pkg::OP_FREE: begin
              out_d.ok    = store_ok;
              out_valid_d = 1'b1;
            end
            bsrm_pkg::OP_MAP: begin
              out_d.ok    = cmd.map_en;
              out_valid_d = 1'b1;
            end
            bsrm_pkg::OP_LOOKUP: begin
              cmp_idx_d = '0;
              state_d   = bsrm_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      bsrm_pkg::ST_SCAN: begin
        if (hit || last) begin
          res_d = '0;
          if (hit) begin
            res_d.ok          = 1'b1;
            res_d.found_store = cmp_idx_q;
            res_d.page_offset = bsrm_pkg::OFS_W'(page_q - mem_rdata);
          end
          state_d = bsrm_pkg::ST_RESP;
        end else begin
          cmp_idx_d = cmp_idx_q + StoreW'(1);
        end
      end
      bsrm_pkg::ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = bsrm_pkg::ST_IDLE;
        end
      end
      default: state_d = bsrm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsrm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cmp_idx_q   <= cmp_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
    if (accept) begin
      pid_q    <= in_pid;
      pid_ok_q <= pid_ok;
      page_q   <= in_vaddr[bsrm_pkg::VADDR_W-1:bsrm_pkg::PAGE_SHIFT];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bsrm_pkg::OUT_DATA_W'(out_q);

  // input is taken only between scans
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == bsrm_pkg::ST_IDLE))
    else $error("input ready outside idle");

  // base page memory is never written while a scan reads it
  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == bsrm_pkg::ST_IDLE))
    else $error("base page write during scan");

  // a pending lookup result never overwrites an item not yet taken
  a_resp_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsrm_pkg::ST_RESP && out_valid_q && !m_axis_tready)
      |=> (state_q == bsrm_pkg::ST_RESP) && $stable(out_q))
    else $error("lookup result overran output register");

  // a lookup hit always reports an offset inside the store's page count
  a_hit_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsrm_pkg::ST_SCAN && hit)
      |-> ({1'b0, bsrm_pkg::OFS_W'(page_q - mem_rdata)} < pages[cmp_idx_q]))
    else $error("lookup offset beyond page count");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the backing store range map unit. A queue of table
// operations (directed corner cases, then random allocate/map/lookup/free
// sequences with noise) is pushed through the slave port in bursts. Each
// accepted item updates a local copy of the store table, and the predicted
// answer is checked against the master port under random receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import bsrm_pkg::*;

  localparam int unsigned NUM_RANDOM_OPS = 1150;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  typedef struct packed {
    opcode_e            op;
    logic [PID_W-1:0]   pid;
    logic [VADDR_W-1:0] vaddr;
    logic [PAGE_W-1:0]  base;
    logic [STORE_W-1:0] store;
    logic [CNT_W-1:0]   pages;
  } table_op_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = OP_GET_FREE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  backing_store_range_map_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Local copy of the store table and the answers it predicts
  // --------------------------------------------------------------------------
  logic                     tbl_mapped [STORE_COUNT];
  logic [CNT_W-1:0]         tbl_pages  [STORE_COUNT];
  logic [PROCESS_COUNT-1:0] tbl_valid  [STORE_COUNT];
  logic [PAGE_W-1:0]        tbl_base   [STORE_COUNT][PROCESS_COUNT];

  result_t   table_answers [$];
  table_op_t op_queue [$];
  int        err_count = 0;
  int        ops_accepted = 0;
  int        ops_total = 0;

  task automatic apply_table_op(input table_op_t r);
    result_t          ans;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W:0]  range_end;
    int               s;
    ans = '0;
    case (r.op)
      OP_GET_FREE: begin
        for (s = 0; s < STORE_COUNT && !ans.ok; s++) begin
          if (!tbl_mapped[s]) begin
            ans.ok = 1'b1;
            ans.found_store = STORE_W'(s);
          end
        end
      end
      OP_FREE: begin
        if (int'(r.store) < STORE_COUNT) begin
          tbl_mapped[r.store] = 1'b0;
          tbl_pages[r.store]  = '0;
          tbl_valid[r.store]  = '0;
          ans.ok = 1'b1;
        end
      end
      OP_MAP: begin
        if (r.pages != 0 && r.pages <= MAX_MAP_PAGES && int'(r.store) < STORE_COUNT &&
            int'(r.pid) < PROCESS_COUNT) begin
          tbl_mapped[r.store]        = 1'b1;
          tbl_pages[r.store]         = r.pages;
          tbl_valid[r.store][r.pid]  = 1'b1;
          tbl_base[r.store][r.pid]   = r.base;
          ans.ok = 1'b1;
        end
      end
      default: begin
        // first store in index order whose range holds the page wins
        page = r.vaddr[VADDR_W-1:PAGE_SHIFT];
        if (int'(r.pid) < PROCESS_COUNT) begin
          for (s = 0; s < STORE_COUNT && !ans.ok; s++) begin
            if (tbl_valid[s][r.pid]) begin
              range_end = {1'b0, tbl_base[s][r.pid]} + tbl_pages[s];
              if (page >= tbl_base[s][r.pid] && {1'b0, page} < range_end) begin
                ans.ok = 1'b1;
                ans.found_store = STORE_W'(s);
                ans.page_offset = OFS_W'(page - tbl_base[s][r.pid]);
              end
            end
          end
        end
      end
    endcase
    table_answers.push_back(ans);
  endtask

  task automatic flag_error(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation: a light shadow of mapped stores steers the sequences
  // --------------------------------------------------------------------------
  logic      gen_mapped [STORE_COUNT];
  table_op_t recent_maps [$];

  task automatic add_op(input opcode_e op, input logic [PID_W-1:0] pid,
                        input logic [VADDR_W-1:0] vaddr, input logic [PAGE_W-1:0] base,
                        input logic [STORE_W-1:0] store, input logic [CNT_W-1:0] pages);
    table_op_t r;
    r = '{op: op, pid: pid, vaddr: vaddr, base: base, store: store, pages: pages};
    op_queue.push_back(r);
    if (op == OP_FREE) begin
      gen_mapped[store] = 1'b0;
    end else if (op == OP_MAP && pages != 0 && pages <= MAX_MAP_PAGES) begin
      gen_mapped[store] = 1'b1;
      recent_maps.push_back(r);
      if (recent_maps.size() > 24) void'(recent_maps.pop_front());
    end
  endtask

  function automatic logic [PID_W-1:0] pick_pid();
    // a few processes share most mappings so that ranges overlap
    if ($urandom_range(0, 3) == 0) return PID_W'($urandom);
    return PID_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [PAGE_W-1:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return PAGE_W'($urandom);
      1:       return 20'hFFFFF - PAGE_W'($urandom_range(0, 200));
      default: return PAGE_W'($urandom_range(0, 'h3FF));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_legal_pages();
    case ($urandom_range(0, 7))
      0:       return CNT_W'(MAX_MAP_PAGES);
      1:       return 8'd1;
      default: return CNT_W'($urandom_range(1, MAX_MAP_PAGES));
    endcase
  endfunction

  task automatic add_lookup();
    table_op_t        rec;
    logic [PAGE_W-1:0] page;
    if (recent_maps.size() != 0 && $urandom_range(0, 4) != 0) begin
      rec  = recent_maps[$urandom_range(0, recent_maps.size() - 1)];
      // one past the end is reached now and then
      page = rec.base + PAGE_W'($urandom_range(0, rec.pages));
      add_op(OP_LOOKUP, ($urandom_range(0, 7) == 0) ? pick_pid() : rec.pid,
             {page, 12'($urandom)}, PAGE_W'($urandom), STORE_W'($urandom), CNT_W'($urandom));
    end else begin
      add_op(OP_LOOKUP, pick_pid(), $urandom, PAGE_W'($urandom), STORE_W'($urandom),
             CNT_W'($urandom));
    end
  endtask

  task automatic add_random_sequence();
    int lowest_free;
    int s;
    int n;
    case ($urandom_range(0, 99)) inside
      [0:24]: begin
        // allocate: ask for a free store and map it
        lowest_free = -1;
        for (s = STORE_COUNT - 1; s >= 0; s--) begin
          if (!gen_mapped[s]) lowest_free = s;
        end
        add_op(OP_GET_FREE, pick_pid(), $urandom, pick_base(), STORE_W'($urandom),
               CNT_W'($urandom));
        if (lowest_free >= 0) begin
          add_op(OP_MAP, pick_pid(), $urandom, pick_base(), STORE_W'(lowest_free),
                 pick_legal_pages());
        end
      end
      [25:59]: begin
        n = $urandom_range(1, 4);
        for (s = 0; s < n; s++) add_lookup();
      end
      [60:69]: begin
        add_op(OP_MAP, pick_pid(), $urandom, pick_base(), STORE_W'($urandom),
               pick_legal_pages());
      end
      [70:84]: begin
        add_op(OP_FREE, pick_pid(), $urandom, PAGE_W'($urandom), STORE_W'($urandom),
               CNT_W'($urandom));
      end
      default: begin
        add_op(opcode_e'($urandom_range(0, 3)), PID_W'($urandom), $urandom,
               PAGE_W'($urandom), STORE_W'($urandom), CNT_W'($urandom));
      end
    endcase
  endtask

  initial begin
    int s;
    for (s = 0; s < STORE_COUNT; s++) begin
      tbl_mapped[s] = 1'b0;
      tbl_pages[s]  = '0;
      tbl_valid[s]  = '0;
      gen_mapped[s] = 1'b0;
      for (int p = 0; p < PROCESS_COUNT; p++) tbl_base[s][p] = '0;
    end

    // directed corner cases
    add_op(OP_GET_FREE, 0, 32'h0, 20'h0, 0, 8'd0);
    add_op(OP_LOOKUP, 0, 32'h0, 20'h0, 0, 8'd0);            // empty table
    add_op(OP_MAP, 0, 32'h0, 20'h0, 0, 8'd128);
    add_op(OP_MAP, 0, 32'h0, 20'h0, 1, 8'd0);               // bad page counts
    add_op(OP_MAP, 0, 32'h0, 20'h0, 1, 8'd129);
    add_op(OP_MAP, 0, 32'h0, 20'h0, 1, 8'd255);
    add_op(OP_LOOKUP, 0, 32'h0007_F123, 20'h0, 0, 8'd0);    // last page of range
    add_op(OP_LOOKUP, 0, 32'h0008_0000, 20'h0, 0, 8'd0);    // just past it
    add_op(OP_LOOKUP, 1, 32'h0000_0000, 20'h0, 0, 8'd0);    // other process
    add_op(OP_MAP, 31, 32'h0, 20'hFFFC0, 1, 8'd128);        // runs past top page
    add_op(OP_LOOKUP, 31, 32'hFFFF_FFFF, 20'hFFFFF, 15, 8'hFF);
    add_op(OP_LOOKUP, 31, 32'hFFFB_FFFF, 20'h0, 0, 8'd0);
    add_op(OP_MAP, 0, 32'h0, 20'h10, 2, 8'd4);              // overlaps store 0
    add_op(OP_LOOKUP, 0, 32'h0001_2000, 20'h0, 0, 8'd0);
    add_op(OP_MAP, 5, 32'h0, 20'h100, 0, 8'd1);             // remap shrinks store 0
    add_op(OP_LOOKUP, 0, 32'h0001_2000, 20'h0, 0, 8'd0);
    add_op(OP_LOOKUP, 5, 32'h0010_0FFF, 20'h0, 0, 8'd0);
    add_op(OP_GET_FREE, 0, 32'h0, 20'h0, 0, 8'd0);
    add_op(OP_FREE, 0, 32'h0, 20'h0, 2, 8'd0);
    add_op(OP_LOOKUP, 0, 32'h0001_2000, 20'h0, 0, 8'd0);
    add_op(OP_GET_FREE, 0, 32'h0, 20'h0, 0, 8'd0);

    while (op_queue.size() < NUM_RANDOM_OPS + 21) add_random_sequence();
    ops_total = op_queue.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of items with random gaps
  // --------------------------------------------------------------------------
  table_op_t cur_op;
  table_op_t next_op;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_GET_FREE;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_table_op(cur_op);
        ops_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || op_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          next_op = op_queue.pop_front();
          cur_op        <= next_op;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_op.op;
          s_axis_tdata  <= {3'b000, next_op.pages, next_op.store, next_op.base,
                            next_op.vaddr, next_op.pid};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern, reloaded once all 32 pattern bits have been used
  // --------------------------------------------------------------------------
  logic [31:0] stall_pat = '1;
  int          stall_phase = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_phase = 0;
    end else begin
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = $urandom & $urandom;  // mostly stalled
          default: stall_pat = $urandom;
        endcase
      end
      m_axis_tready <= stall_pat[stall_phase];
      stall_phase = (stall_phase + 1) % 32;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  result_t got;
  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[OFS_W+STORE_W:0]);
      if (table_answers.size() == 0) begin
        flag_error($sformatf("unexpected item ok=%0d store=%0d offset=%0d",
                             got.ok, got.found_store, got.page_offset));
      end else begin
        want = table_answers.pop_front();
        if (got.ok !== want.ok)
          flag_error($sformatf("ok: got %0d, want %0d", got.ok, want.ok));
        if (got.found_store !== want.found_store)
          flag_error($sformatf("found_store: got %0d, want %0d",
                               got.found_store, want.found_store));
        if (got.page_offset !== want.page_offset)
          flag_error($sformatf("page_offset: got %0d, want %0d",
                               got.page_offset, want.page_offset));
      end
    end
  end

  // --------------------------------------------------------------------------
  // End of run and timeout
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    while (ops_accepted < ops_total || table_answers.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("** backing_store_range_map_unit: PASSED **");
    end else begin
      $display("** backing_store_range_map_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
             table_answers.size());
    $display("** backing_store_range_map_unit: FAILED **");
    $finish;
  end

endmodule
